// File: rtl/uer_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg: shared definitions for the ultrasonic echo ranger
// Field widths, register indexes, phase codes, reset values and the
// reciprocal constant used for the tick-to-millimeter scaling.
// ----------------------------------------------------------------------------
package uer_pkg;

  // field widths
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned TRIG_W     = 8;
  localparam int unsigned DIST_W     = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_TIMEOUT  = 2'd2;

  // configuration reset values
  localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 8'd20;
  localparam logic [TICK_W-1:0] RISE_TIMEOUT_RST  = 16'd60000;
  localparam logic [TICK_W-1:0] FALL_TIMEOUT_RST  = 16'd50000;

  // measurement phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TRIG = 2'd1;
  localparam logic [1:0] PH_RISE = 2'd2;
  localparam logic [1:0] PH_FALL = 2'd3;

  // ticks*343/4000 as ticks*ceil(343*2^30/4000) >> 30, exact for 16-bit ticks
  localparam int unsigned   DIST_SHIFT  = 30;
  localparam int unsigned   DIST_MULT_W = 27;
  localparam logic [DIST_MULT_W-1:0] DIST_MULT = 27'd92073362;
  localparam int unsigned   DIST_PROD_W = TICK_W + DIST_MULT_W;

endpackage : uer_pkg
`default_nettype wire

// File: rtl/uer_intf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uer_intf: handshake channels of the ultrasonic echo ranger
// Tick request channel, result channel and configuration write channel,
// each with valid/ready and its payload.
// ----------------------------------------------------------------------------

// tick request channel
interface uer_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic echo_level;

  modport source (output valid, output mode, output echo_level, input ready);
  modport sink   (input valid, input mode, input echo_level, output ready);
endinterface : uer_in_if

// result channel
interface uer_out_if import uer_pkg::*;;
  logic              valid;
  logic              ready;
  logic              trigger_level;
  logic              busy_res;
  logic              done_res;
  logic              no_echo;
  logic [TICK_W-1:0] echo_ticks;
  logic [DIST_W-1:0] range_mm;

  modport source (output valid, output trigger_level, output busy_res,
                  output done_res, output no_echo, output echo_ticks,
                  output range_mm, input ready);
  modport sink   (input valid, input trigger_level, input busy_res,
                  input done_res, input no_echo, input echo_ticks,
                  input range_mm, output ready);
endinterface : uer_out_if

// configuration write channel
interface uer_cfg_if import uer_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : uer_cfg_if
`default_nettype wire

// File: rtl/ultrasonic_echo_ranger.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: time-of-flight range measurement
// Per 0.5 us tick: trigger pulse, wait for echo rise, time echo high,
// report echo ticks and distance in millimeters, or no_echo on timeout.
// ----------------------------------------------------------------------------
// the result of a tick request is registered at accept and presented in the next cycle
// throughput: one tick request per cycle while the result is taken; the phase/count update and the
//   single 16x27 scaling multiply sit between the state and result registers
// a waiting result stalls the input unless it leaves in the same cycle
// reset: phase idle, count and echo history zero, registers to defaults
//   (trigger 20, rise timeout 60000, fall timeout 50000), no result pending
module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  uer_in_if.sink     in_ch,
  uer_out_if.source  out_ch,
  uer_cfg_if.sink    cfg
);

  // configuration registers
  logic [TRIG_W-1:0] trigger_ticks;
  logic [TICK_W-1:0] rise_timeout;
  logic [TICK_W-1:0] fall_timeout;

  // measurement state
  logic [1:0]        phase, phase_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic              echo_prev;

  // result register
  logic              out_valid;
  logic              trig_q, busy_q, done_q, noecho_q;
  logic [TICK_W-1:0] ticks_q;
  logic [DIST_W-1:0] dist_q;

  logic              in_accept;
  logic              rise, fall;
  logic [TRIG_W-1:0] trig_len;
  logic [TICK_W-1:0] cnt_inc;
  logic              trig_c, done_c, noecho_c, echo_done_c;
  logic [DIST_PROD_W-1:0] dist_prod;

  assign cfg.ready    = 1'b1;
  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign in_accept    = in_ch.valid && in_ch.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks <= TRIGGER_TICKS_RST;
      rise_timeout  <= RISE_TIMEOUT_RST;
      fall_timeout  <= FALL_TIMEOUT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TRIGGER_TICKS: trigger_ticks <= cfg.data[TRIG_W-1:0];
        REG_RISE_TIMEOUT:  rise_timeout  <= cfg.data;
        REG_FALL_TIMEOUT:  fall_timeout  <= cfg.data;
        default: ;
      endcase
    end
  end

  // edge detect, trigger length and saturating count
  assign rise     = in_ch.echo_level && !echo_prev;
  assign fall     = !in_ch.echo_level && echo_prev;
  assign trig_len = (trigger_ticks == '0) ? TRIG_W'(1) : trigger_ticks;
  assign cnt_inc  = (tick_count == '1) ? tick_count : tick_count + TICK_W'(1);

  // phase sequencing
  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    trig_c          = 1'b0;
    done_c          = 1'b0;
    noecho_c        = 1'b0;
    echo_done_c     = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (in_ch.mode) begin
          trig_c = 1'b1;
          if (trig_len == TRIG_W'(1)) begin
            phase_next      = PH_RISE;
            tick_count_next = '0;
          end else begin
            phase_next      = PH_TRIG;
            tick_count_next = TICK_W'(1);
          end
        end
      end
      PH_TRIG: begin
        trig_c          = 1'b1;
        tick_count_next = cnt_inc;
        if (cnt_inc >= TICK_W'(trig_len)) begin
          phase_next      = PH_RISE;
          tick_count_next = '0;
        end
      end
      PH_RISE: begin
        tick_count_next = cnt_inc;
        if (rise) begin
          phase_next      = PH_FALL;
          tick_count_next = '0;
        end else if (cnt_inc >= rise_timeout) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          done_c          = 1'b1;
          noecho_c        = 1'b1;
        end
      end
      default: begin
        tick_count_next = cnt_inc;
        if (fall) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          done_c          = 1'b1;
          echo_done_c     = 1'b1;
        end else if (cnt_inc >= fall_timeout) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          done_c          = 1'b1;
          noecho_c        = 1'b1;
        end
      end
    endcase
  end

  // distance scaling by reciprocal multiply
  assign dist_prod = DIST_PROD_W'(cnt_inc) * DIST_PROD_W'(DIST_MULT);

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      echo_prev  <= 1'b0;
    end else if (in_accept) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      echo_prev  <= in_ch.echo_level;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      trig_q   <= trig_c;
      busy_q   <= (phase_next != PH_IDLE);
      done_q   <= done_c;
      noecho_q <= noecho_c;
      ticks_q  <= echo_done_c ? cnt_inc : '0;
      dist_q   <= echo_done_c ? dist_prod[DIST_SHIFT +: DIST_W] : '0;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.trigger_level = trig_q;
  assign out_ch.busy_res      = busy_q;
  assign out_ch.done_res      = done_q;
  assign out_ch.no_echo       = noecho_q;
  assign out_ch.echo_ticks    = ticks_q;
  assign out_ch.range_mm      = dist_q;

  // a finished measurement never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_q) |-> !busy_q)
    else $error("done reported together with busy");

  // timeout results carry no measurement
  a_noecho_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && noecho_q) |-> (done_q && ticks_q == '0 && dist_q == '0))
    else $error("no_echo result with nonzero measurement");

  // counter is cleared whenever the block is idle
  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tick_count == '0))
    else $error("tick count nonzero in idle");

  // an idle tick without start keeps the block idle
  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    (in_accept && phase == PH_IDLE && !in_ch.mode) |=> (phase == PH_IDLE && !busy_q))
    else $error("left idle without a start request");

  // trigger is driven only on the start tick or in the trigger phase
  a_trig_source: assert property (@(posedge clk) disable iff (rst)
    (in_accept && trig_c) |-> (phase == PH_TRIG || (phase == PH_IDLE && in_ch.mode)))
    else $error("trigger driven outside trigger phase");

endmodule : ultrasonic_echo_ranger
`default_nettype wire
